FILE: design/vdenc_pkg.sv
// ----------------------------------------------------------------------------
// vdenc_pkg
// Shared types for the value dictionary encoder: field types of the two
// streams and the control bundle that drives the cell chain.
// ----------------------------------------------------------------------------
package vdenc_pkg;

    // widths of the stream fields
    typedef logic [63:0] value_word_t;
    typedef logic [7:0]  index_out_t;
    typedef logic [8:0]  count_out_t;

    // control bundle broadcast to every cell of the chain
    typedef struct packed {
        logic start;    // new search, token enters cell 0
        logic advance;  // token moves one cell down the chain
        logic finish;   // search ends, token is removed
        logic write;    // cell holding the token stores the key
    } chain_ctrl_t;

endpackage

FILE: design/vdenc_in_if.sv
// ----------------------------------------------------------------------------
// vdenc_in_if
// Input stream of the value dictionary encoder: one raw value per
// transaction plus the end-of-matrix marker.
// ----------------------------------------------------------------------------
interface vdenc_in_if;

    logic                   valid;
    logic                   ready;
    vdenc_pkg::value_word_t value_bits;
    logic                   last;

    modport source
    (
        output valid,
        output value_bits,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  value_bits,
        input  last,
        output ready
    );

endinterface

FILE: design/vdenc_out_if.sv
// ----------------------------------------------------------------------------
// vdenc_out_if
// Result stream of the value dictionary encoder: dictionary index, flags
// and running unique count per transaction.
// ----------------------------------------------------------------------------
interface vdenc_out_if;

    logic                  valid;
    logic                  ready;
    vdenc_pkg::index_out_t value_index;
    logic                  is_new;
    vdenc_pkg::count_out_t unique_count;
    logic                  overflow;
    logic                  last_out;

    modport source
    (
        output valid,
        output value_index,
        output is_new,
        output unique_count,
        output overflow,
        output last_out,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  value_index,
        input  is_new,
        input  unique_count,
        input  overflow,
        input  last_out,
        output ready
    );

endinterface

FILE: design/vdenc_cell.sv
// ----------------------------------------------------------------------------
// vdenc_cell
// One dictionary entry. Holds a stored value and a search token; compares
// the broadcast key while it holds the token and passes the token on.
// ----------------------------------------------------------------------------
module vdenc_cell #(
    parameter int VALUE_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vdenc_pkg::chain_ctrl_t ctrl,
    input  logic [VALUE_BITS-1:0]  key,
    input  logic                   load_token,
    input  logic                   token_in,
    output logic                   token_out,
    output logic                   hit
);

    logic                  token_reg;
    logic                  token_next;
    logic [VALUE_BITS-1:0] value_reg;

    always_comb
    begin
        priority if (ctrl.start)
        begin
            token_next = load_token;
        end
        else if (ctrl.finish)
        begin
            token_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            token_next = token_in;
        end
        else
        begin
            token_next = token_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    // entry storage, written only by the cell the token sits in
    always_ff @(posedge clk)
    begin
        if (ctrl.write && token_reg)
        begin
            value_reg <= key;
        end
    end

    assign token_out = token_reg;
    assign hit       = token_reg && (value_reg == key);

endmodule

FILE: design/vdenc_chain.sv
// ----------------------------------------------------------------------------
// vdenc_chain
// Row of dictionary cells. The search token walks one cell per cycle while
// advance is set; the match flags of all cells merge into one hit signal.
// ----------------------------------------------------------------------------
module vdenc_chain #(
    parameter int INDEX_BITS = 8,
    parameter int VALUE_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vdenc_pkg::chain_ctrl_t ctrl,
    input  logic [VALUE_BITS-1:0]  key,
    output logic                   hit_any
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [DEPTH-1:0] tokens;
    logic [DEPTH-1:0] hits;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                vdenc_cell #(
                    .VALUE_BITS (VALUE_BITS)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .key        (key),
                    .load_token (1'b1),
                    .token_in   (1'b0),
                    .token_out  (tokens[k]),
                    .hit        (hits[k])
                );
            end
            else
            begin : g_body
                vdenc_cell #(
                    .VALUE_BITS (VALUE_BITS)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .key        (key),
                    .load_token (1'b0),
                    .token_in   (tokens[k-1]),
                    .token_out  (tokens[k]),
                    .hit        (hits[k])
                );
            end
        end
    endgenerate

    // only the cell holding the token can report a hit
    assign hit_any = |hits;

endmodule

FILE: design/value_dictionary_encoder_top.sv
// ----------------------------------------------------------------------------
// value_dictionary_encoder_top
// Dictionary encoder for a stream of raw values: hit returns the stored
// index, miss appends the value and flags it new, full table flags overflow.
//
//   channel      modport  transaction carries
//   in_stream    sink     value_bits, last
//   out_stream   source   value_index, is_new, unique_count, overflow,
//                         last_out
//
// a search token walks the cell chain one entry per cycle and stops at the
// first match, at the first free entry or at the last entry. the result of
// an item is registered once its search has stopped and the output register
// is free; the next item is accepted in the cycle after the result is
// registered. reset empties the dictionary at once. a stalled result holds
// the token in its last cell until it is taken.
// ----------------------------------------------------------------------------
module value_dictionary_encoder_top #(
    parameter int INDEX_BITS = 8,
    parameter int VALUE_BITS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    vdenc_in_if.sink     in_stream,
    vdenc_out_if.source  out_stream
);

    localparam int COUNT_BITS = INDEX_BITS + 1;
    localparam logic [INDEX_BITS-1:0] LAST_POS = '1;

    logic                   busy_reg;
    logic                   busy_next;
    logic [INDEX_BITS-1:0]  pos_reg;
    logic [INDEX_BITS-1:0]  pos_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [VALUE_BITS-1:0]  key_reg;
    logic                   last_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    vdenc_pkg::index_out_t  out_index_reg;
    logic                   out_new_reg;
    vdenc_pkg::count_out_t  out_count_reg;
    logic                   out_ovf_reg;
    logic                   out_last_reg;

    vdenc_pkg::chain_ctrl_t ctrl;
    logic                   hit_any;
    logic                   accept;
    logic                   occupied;
    logic                   hit;
    logic                   stop;
    logic                   out_free;
    logic                   finish;
    logic                   append;
    logic                   ovf;
    logic [COUNT_BITS-1:0]  count_after;
    logic [INDEX_BITS-1:0]  result_index;

    assign in_stream.ready = !busy_reg;
    assign accept          = in_stream.valid && !busy_reg;

    // entries below the count are filled
    assign occupied = ({1'b0, pos_reg} < count_reg);
    assign hit      = hit_any && occupied;
    assign stop     = busy_reg && (hit || !occupied || (pos_reg == LAST_POS));
    assign out_free = !out_valid_reg || out_stream.ready;
    assign finish   = stop && out_free;
    assign append   = finish && !hit && !occupied;
    assign ovf      = !hit && occupied;

    assign ctrl.start   = accept;
    assign ctrl.advance = busy_reg && !stop;
    assign ctrl.finish  = finish;
    assign ctrl.write   = append;

    assign count_after  = append ? (count_reg + 1'b1) : count_reg;
    assign result_index = ovf ? '0 : pos_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = '0;
        end
        else if (ctrl.advance)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (finish)
        begin
            count_next = last_reg ? '0 : count_after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= in_stream.value_bits[VALUE_BITS-1:0];
            last_reg <= in_stream.last;
        end
        if (finish)
        begin
            out_index_reg <= vdenc_pkg::index_out_t'(result_index);
            out_new_reg   <= append;
            out_count_reg <= vdenc_pkg::count_out_t'(count_after);
            out_ovf_reg   <= ovf;
            out_last_reg  <= last_reg;
        end
    end

    vdenc_chain #(
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .key     (key_reg),
        .hit_any (hit_any)
    );

    assign out_stream.valid        = out_valid_reg;
    assign out_stream.value_index  = out_index_reg;
    assign out_stream.is_new       = out_new_reg;
    assign out_stream.unique_count = out_count_reg;
    assign out_stream.overflow     = out_ovf_reg;
    assign out_stream.last_out     = out_last_reg;

endmodule

FILE: design/vdenc_checker.sv
// ----------------------------------------------------------------------------
// vdenc_checker
// Port-level checks for the value dictionary encoder, bound to the top.
// ----------------------------------------------------------------------------
module vdenc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input vdenc_pkg::index_out_t value_index,
    input logic                  is_new,
    input vdenc_pkg::count_out_t unique_count,
    input logic                  overflow,
    input logic                  last_out
);

    // set while the dictionary is known to be empty for the next result
    logic fresh_reg;
    logic fresh_next;

    always_comb
    begin
        fresh_next = fresh_reg;
        if (out_valid && out_ready)
        begin
            fresh_next = last_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
        end
        else
        begin
            fresh_reg <= fresh_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({value_index, is_new, unique_count, overflow, last_out}))
        else $error("stalled result changed");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken during a search");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && overflow))
        else $error("new and overflow raised together");

    a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> value_index == '0)
        else $error("overflow with nonzero index");

    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fresh_reg |-> is_new && value_index == '0)
        else $error("first value of an empty dictionary not appended at 0");

endmodule

bind value_dictionary_encoder_top vdenc_checker u_vdenc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_stream.valid),
    .in_ready     (in_stream.ready),
    .out_valid    (out_stream.valid),
    .out_ready    (out_stream.ready),
    .value_index  (out_stream.value_index),
    .is_new       (out_stream.is_new),
    .unique_count (out_stream.unique_count),
    .overflow     (out_stream.overflow),
    .last_out     (out_stream.last_out)
);
